FILE: rtl/srw_pkg.sv
package srw_pkg;

    localparam int NUM_STREAMS = 16;
    localparam int WINDOW_SIZE = 64;
    localparam int SSRC_W      = 32;
    localparam int IDX_W       = 31;
    localparam int SLOT_W      = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int ENTRY_W     = IDX_W + WINDOW_SIZE;

    localparam logic [2:0] ST_FIRST   = 3'd0;
    localparam logic [2:0] ST_NEWHIGH = 3'd1;
    localparam logic [2:0] ST_INWIN   = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_OLD     = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_OFF     = 3'd6;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic  hit;
        t_slot hit_slot;
        logic  free_found;
        t_slot free_slot;
    } t_match;

    typedef struct packed {
        logic              en;
        t_slot             slot;
        logic [SSRC_W-1:0] tag;
    } t_alloc;

endpackage

FILE: rtl/srw_ram.sv
module srw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/srw_tags.sv
module srw_tags (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [srw_pkg::SSRC_W-1:0] i_ssrc,
    input  srw_pkg::t_alloc          i_alloc,
    output srw_pkg::t_match          o_match
);
    import srw_pkg::*;

    logic [NUM_STREAMS-1:0] r_valid;
    logic [SSRC_W-1:0]      r_tag [NUM_STREAMS];
    t_match                 match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_alloc.en) begin
            r_valid[i_alloc.slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc.en) begin
            r_tag[i_alloc.slot] <= i_alloc.tag;
        end
    end

    // lowest matching entry and lowest free entry
    always_comb begin
        match = '0;
        for (int k = NUM_STREAMS - 1; k >= 0; k--) begin
            if (r_valid[k]) begin
                if (r_tag[k] == i_ssrc) begin
                    match.hit      = 1'b1;
                    match.hit_slot = t_slot'(k);
                end
            end else begin
                match.free_found = 1'b1;
                match.free_slot  = t_slot'(k);
            end
        end
    end

    assign o_match = match;

endmodule

FILE: rtl/srtcp_replay_window.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_ssrc, i_packet_index
// output    out        o_out_valid / i_out_stall  o_accept, o_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_enable
//
// packets are taken one at a time: accept, tag match with stream ram read, check and write back
// the stream ram has one port per direction and a registered read
// reset clears the valid marks of all streams and the enable register
// a result waits in the output register while the next packet is accepted and matched;
// the check stage holds until that register is free
module srtcp_replay_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [srw_pkg::SSRC_W-1:0] i_ssrc,
    input  logic [srw_pkg::IDX_W-1:0]  i_packet_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accept,
    output logic [2:0]                o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_enable
);
    import srw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_enable;

    logic [SSRC_W-1:0] r_ssrc;
    logic [IDX_W-1:0]  r_idx;
    t_match            r_match;
    t_match            match;
    t_alloc            alloc;

    logic               r_out_valid, n_out_valid;
    logic               r_accept, n_accept;
    logic [2:0]         r_status, n_status;

    logic               wr_en;
    t_slot              wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic [IDX_W-1:0]       hi;
    logic [WINDOW_SIZE-1:0] bm;
    logic [IDX_W-1:0]       ahead;
    logic [IDX_W-1:0]       back;
    logic [WINDOW_SIZE-1:0] bit_mask;
    logic [2:0]             status;
    logic                   out_free;
    logic                   commit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign commit      = (r_state == S_CHECK) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_enable;
        end
    end

    srw_tags u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ssrc  (r_ssrc),
        .i_alloc (alloc),
        .o_match (match)
    );

    srw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_STREAMS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (r_state == S_MATCH),
        .i_rd_addr (match.hit_slot),
        .o_rd_data (rd_data)
    );

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (i_in_valid) ? S_MATCH : S_IDLE;
            S_MATCH: n_state = S_CHECK;
            S_CHECK: n_state = (out_free) ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_ssrc <= i_ssrc;
            r_idx  <= i_packet_index;
        end
        if (r_state == S_MATCH) begin
            r_match <= match;
        end
    end

    // window check on the entry read back
    always_comb begin
        hi       = rd_data[ENTRY_W-1:WINDOW_SIZE];
        bm       = rd_data[WINDOW_SIZE-1:0];
        ahead    = r_idx - hi;
        back     = hi - r_idx;
        bit_mask = WINDOW_SIZE'(1) << back[$clog2(WINDOW_SIZE)-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_match.hit_slot;
        wr_data  = rd_data;
        alloc    = '0;
        alloc.slot = r_match.free_slot;
        alloc.tag  = r_ssrc;
        if (!r_enable) begin
            status = ST_OFF;
        end else if (!r_match.hit) begin
            if (!r_match.free_found) begin
                status = ST_FULL;
            end else begin
                status   = ST_FIRST;
                wr_en    = commit;
                wr_addr  = r_match.free_slot;
                wr_data  = {r_idx, WINDOW_SIZE'(1)};
                alloc.en = commit;
            end
        end else if (r_idx > hi) begin
            status = ST_NEWHIGH;
            wr_en  = commit;
            if (ahead >= IDX_W'(WINDOW_SIZE)) begin
                wr_data = {r_idx, WINDOW_SIZE'(1)};
            end else begin
                wr_data = {r_idx,
                           (bm << ahead[$clog2(WINDOW_SIZE)-1:0]) | WINDOW_SIZE'(1)};
            end
        end else if (back >= IDX_W'(WINDOW_SIZE)) begin
            status = ST_OLD;
        end else if ((bm & bit_mask) != '0) begin
            status = ST_DUP;
        end else begin
            status  = ST_INWIN;
            wr_en   = commit;
            wr_data = {hi, bm | bit_mask};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_accept    = r_accept;
        n_status    = r_status;
        if (commit) begin
            n_out_valid = 1'b1;
            n_accept    = (status == ST_FIRST) || (status == ST_NEWHIGH)
                       || (status == ST_INWIN);
            n_status    = status;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accept <= n_accept;
        r_status <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_accept    = r_accept;
    assign o_status    = r_status;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import srw_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int LONG_HOLD  = 150;

    typedef struct packed {
        logic       accept;
        logic [2:0] status;
    } t_verdict;

    typedef struct packed {
        logic              en;
        logic [SSRC_W-1:0] ssrc;
        logic [IDX_W-1:0]  idx;
        logic              known;
        logic [2:0]        status;
    } t_probe;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [SSRC_W-1:0] i_ssrc;
    logic [IDX_W-1:0]  i_packet_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_accept;
    logic [2:0]        o_status;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_enable;

    logic [SSRC_W-1:0]      tag_tbl  [NUM_STREAMS];
    logic                   live_tbl [NUM_STREAMS];
    logic [IDX_W-1:0]       top_idx  [NUM_STREAMS];
    logic [WINDOW_SIZE-1:0] seen_map [NUM_STREAMS];
    logic                   enable_mirror = 1'b0;

    t_verdict verdict_q [$];
    int error_count = 0;
    int status_tally [0:6];
    int send_idle = 0;
    int recv_idle = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    t_probe probes [18] = '{
        '{1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, ST_OFF},
        '{1'b1, 32'h0000_0000, 31'd0,         1'b1, ST_FIRST},
        '{1'b1, 32'h0000_0000, 31'd0,         1'b1, ST_DUP},
        '{1'b1, 32'h0000_0000, 31'd63,        1'b1, ST_NEWHIGH},
        '{1'b1, 32'h0000_0000, 31'd0,         1'b1, ST_DUP},
        '{1'b1, 32'h0000_0000, 31'd1,         1'b1, ST_INWIN},
        '{1'b1, 32'h0000_0000, 31'd127,       1'b1, ST_NEWHIGH},
        '{1'b1, 32'h0000_0000, 31'd63,        1'b1, ST_OLD},
        '{1'b1, 32'h0000_0000, 31'd64,        1'b1, ST_INWIN},
        '{1'b1, 32'h0000_0000, 31'd100,       1'b0, ST_FIRST},
        '{1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, ST_FIRST},
        '{1'b1, 32'hFFFF_FFFF, 31'd0,         1'b1, ST_OLD},
        '{1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFC1, 1'b0, ST_FIRST},
        '{1'b0, 32'h0000_0000, 31'd200,       1'b1, ST_OFF},
        '{1'b1, 32'h0000_0000, 31'd128,       1'b1, ST_NEWHIGH},
        '{1'b1, 32'h0000_0000, 31'd127,       1'b1, ST_DUP},
        '{1'b1, 32'hA5A5_A5A5, 31'h5A5A_5A5A, 1'b0, ST_FIRST},
        '{1'b1, 32'h5A5A_5A5A, 31'h25A5_A5A5, 1'b0, ST_FIRST}
    };

    srtcp_replay_window dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ssrc         (i_ssrc),
        .i_packet_index (i_packet_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accept       (o_accept),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_enable   (i_cfg_enable)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int find_stream(logic [SSRC_W-1:0] s);
        for (int k = 0; k < NUM_STREAMS; k++) begin
            if (live_tbl[k] && tag_tbl[k] == s) return k;
        end
        return -1;
    endfunction

    function automatic logic [2:0] replay_verdict(logic [SSRC_W-1:0] s, logic [IDX_W-1:0] x);
        int hit;
        int free_slot;
        logic [IDX_W-1:0] gap;
        hit = find_stream(s);
        free_slot = -1;
        if (!enable_mirror) return ST_OFF;
        if (hit < 0) begin
            for (int k = NUM_STREAMS - 1; k >= 0; k--) begin
                if (!live_tbl[k]) free_slot = k;
            end
            if (free_slot < 0) return ST_FULL;
            live_tbl[free_slot] = 1'b1;
            tag_tbl[free_slot] = s;
            top_idx[free_slot] = x;
            seen_map[free_slot] = 64'd1;
            return ST_FIRST;
        end
        if (x > top_idx[hit]) begin
            gap = x - top_idx[hit];
            if (gap >= WINDOW_SIZE) seen_map[hit] = '0;
            else seen_map[hit] = seen_map[hit] << gap;
            seen_map[hit][0] = 1'b1;
            top_idx[hit] = x;
            return ST_NEWHIGH;
        end
        gap = top_idx[hit] - x;
        if (gap >= WINDOW_SIZE) return ST_OLD;
        if (seen_map[hit][gap]) return ST_DUP;
        seen_map[hit][gap] = 1'b1;
        return ST_INWIN;
    endfunction

    // one transaction per accepted packet, verdict predicted at acceptance
    task automatic send_packet(input logic [SSRC_W-1:0] s, input logic [IDX_W-1:0] x,
                               input logic known, input logic [2:0] known_status);
        logic [2:0] st;
        t_verdict v;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ssrc <= s;
        i_packet_index <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        st = replay_verdict(s, x);
        if (known) st = known_status;
        v.accept = (st <= ST_INWIN);
        v.status = st;
        verdict_q.insert(verdict_q.size(), v);
    endtask

    task automatic random_packet();
        int pick;
        int slot;
        int unsigned ahead;
        int unsigned back;
        logic [SSRC_W-1:0] s;
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] x;
        pick = $urandom_range(99);
        slot = $urandom_range(NUM_STREAMS - 1);
        s = tag_tbl[slot];
        top = top_idx[slot];
        if (pick < 6) begin
            s = $urandom;
            x = IDX_W'($urandom);
        end else if (pick < 9) begin
            x = IDX_W'($urandom);
        end else begin
            if (pick < 45) ahead = $urandom_range(4, 1);
            else if (pick < 55) ahead = $urandom_range(90, 5);
            else ahead = 0;
            back = (pick < 93) ? $urandom_range(63, 0) : $urandom_range(300, 64);
            if (ahead != 0 && top <= 31'h7FFF_FFFF - ahead) x = IDX_W'(top + ahead);
            else if (top >= back) x = IDX_W'(top - back);
            else x = top;
        end
        send_packet(s, x, 1'b0, ST_FIRST);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_enable <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        enable_mirror = v;
    endtask

    initial begin
        #(CLK_PERIOD * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: stall pattern, long holds on request, verdict check
    initial begin
        t_verdict want;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no packet outstanding: accept %0d status %0d",
                           o_accept, o_status);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    status_tally[want.status]++;
                    if (o_accept !== want.accept) begin
                        $error("accept: expected %0d, actual %0d", want.accept, o_accept);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    initial begin
        logic [SSRC_W-1:0] s;
        logic [IDX_W-1:0] x;
        for (int k = 0; k < NUM_STREAMS; k++) begin
            tag_tbl[k] = '0;
            live_tbl[k] = 1'b0;
            top_idx[k] = '0;
            seen_map[k] = '0;
        end
        for (int k = 0; k <= 6; k++) status_tally[k] = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_ssrc = '0;
        i_packet_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_enable = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < 18; r++) begin
            if (probes[r].en != enable_mirror) write_enable(probes[r].en);
            send_packet(probes[r].ssrc, probes[r].idx, probes[r].known, probes[r].status);
        end
        // fill the stream table, the last new ssrc finds it full
        for (int k = 0; k < 13; k++) begin
            do s = $urandom; while (find_stream(s) >= 0);
            x = (k % 3 == 0) ? IDX_W'($urandom_range(31'h7FFF_0000, 31'h7000_0000))
                             : IDX_W'($urandom_range(5000, 0));
            send_packet(s, x, 1'b0, ST_FIRST);
        end

        send_idle = 33;
        recv_idle = 61;
        repeat (460) random_packet();
        write_enable(1'b0);
        repeat (15) random_packet();
        write_enable(1'b1);

        send_idle = 61;
        recv_idle = 33;
        repeat (230) random_packet();
        send_idle = 0;
        hold_asked++;
        repeat (40) random_packet();
        wait_drained();
        send_idle = 61;
        repeat (230) random_packet();

        send_idle = 0;
        recv_idle = 0;
        repeat (460) random_packet();
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("checked %0d first, %0d new highest, %0d in window, %0d duplicate",
                 status_tally[ST_FIRST], status_tally[ST_NEWHIGH],
                 status_tally[ST_INWIN], status_tally[ST_DUP]);
        $display("%0d too old, %0d table full, %0d disabled, with %0d long output hold",
                 status_tally[ST_OLD], status_tally[ST_FULL], status_tally[ST_OFF],
                 hold_served);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
